### hw/rtl/bpd_pkg.sv
// bpd_pkg: shared types, codes and constants of the bang packet deframer.
// No dependencies; imported by every module of the block except bpd_ram.
package bpd_pkg;

    localparam int MAX_FRAME_DEF = 20;   // default frame store depth in bytes
    localparam int DQ_DEPTH_DEF  = 4;    // descriptor queue depth (power of two)
    localparam int LEN_W         = 6;    // holds any frame length up to 63
    localparam int BYTE_W        = 8;
    localparam int POS_W         = 5;    // width of position and length result fields
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_A       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_C       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_D       = 3'd4;

    localparam logic [CFG_W-1:0]  IDLE_TIMEOUT_RST = 16'd1000;
    localparam logic [BYTE_W-1:0] START_MARK       = 8'h21;   // '!'

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam logic STAT_GOOD = 1'b0;
    localparam logic STAT_BAD  = 1'b1;

    typedef logic [LEN_W-1:0] t_len;

    // closed frame handed from front to back
    typedef struct packed {
        logic err;
        logic bank;
        t_len len;
    } t_desc;

    // bank handed back to the front once its replay has been read out
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  len;
        logic              last;
    } t_result;

endpackage

### hw/rtl/bpd_ram.sv
// bpd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bpd_front.sv
// bpd_front: configuration registers, byte collection, frame close and checksum test.
// Depends on bpd_pkg; writes frame bytes into the ping-pong frame RAM.
module bpd_front
    import bpd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_opcode,
    input  logic [BYTE_W-1:0]                 i_rx_byte,
    input  logic                              i_cfg_we,
    input  logic [CFG_IDX_W-1:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]                  i_cfg_data,
    input  logic                              i_dq_full,
    output logic                              o_dq_push,
    output t_desc                             o_desc,
    input  t_release                          i_rel,
    output logic                              o_mem_we,
    output logic [$clog2(2*MAX_FRAME)-1:0]    o_mem_addr,
    output logic [BYTE_W-1:0]                 o_mem_data
);

    localparam int AW = $clog2(2*MAX_FRAME);

    logic [CFG_W-1:0]  r_idle_timeout;
    logic [CFG_W-1:0]  r_rule [4];
    t_len              r_fill;
    logic [BYTE_W-1:0] r_excl;      // sum of stored bytes except the last one
    logic [BYTE_W-1:0] r_last;
    logic [BYTE_W-1:0] r_type;
    logic [CFG_W-1:0]  r_idle;
    logic              r_bank;
    logic [1:0]        r_busy;
    logic [1:0]        n_busy;

    logic              acc, is_byte, store, tick, rule_hit, len_hit;
    logic              byte_close, tick_close, close, bad;
    t_len              fill_new, close_len;
    logic [BYTE_W-1:0] excl_new, type_new, close_excl, close_last;
    logic [CFG_W-1:0]  idle_inc, limit;

    assign o_full  = i_dq_full || r_busy[r_bank];
    assign acc     = i_push && !o_full;
    assign is_byte = (i_opcode == OP_BYTE);
    assign store   = acc && is_byte && (r_fill != '0 || i_rx_byte == START_MARK);
    assign tick    = acc && !is_byte && (r_fill != '0);

    assign fill_new = r_fill + t_len'(1);
    assign excl_new = (r_fill == '0) ? '0 : r_excl + r_last;
    assign type_new = (r_fill == t_len'(1)) ? i_rx_byte : r_type;

    always_comb begin
        rule_hit = 1'b0;
        for (int r = 0; r < 4; r++) begin
            if (r_rule[r][15:8] == type_new && r_rule[r][7:0] == BYTE_W'(fill_new)) begin
                rule_hit = 1'b1;
            end
        end
    end

    assign len_hit = (fill_new >= t_len'(MAX_FRAME)) || (fill_new >= t_len'(2) && rule_hit);

    assign idle_inc = (r_idle == '1) ? r_idle : r_idle + CFG_W'(1);
    assign limit    = (r_idle_timeout == '0) ? CFG_W'(1) : r_idle_timeout;

    assign byte_close = store && len_hit;
    assign tick_close = tick && (idle_inc >= limit);
    assign close      = byte_close || tick_close;

    assign close_len  = byte_close ? fill_new  : r_fill;
    assign close_excl = byte_close ? excl_new  : r_excl;
    assign close_last = byte_close ? i_rx_byte : r_last;
    assign bad        = (~close_excl != close_last);

    assign o_dq_push   = close;
    assign o_desc.err  = bad;
    assign o_desc.bank = r_bank;
    assign o_desc.len  = close_len;

    assign o_mem_we   = store;
    assign o_mem_addr = (r_bank ? AW'(MAX_FRAME) : AW'(0)) + AW'(r_fill);
    assign o_mem_data = i_rx_byte;

    // released bank and newly owned bank are never the same one
    always_comb begin
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        // good frame: its bank stays owned by the back end until replayed
        if (close && !bad) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= IDLE_TIMEOUT_RST;
            for (int r = 0; r < 4; r++) begin
                r_rule[r] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data;
                CFG_RULE_A:       r_rule[0]      <= i_cfg_data;
                CFG_RULE_B:       r_rule[1]      <= i_cfg_data;
                CFG_RULE_C:       r_rule[2]      <= i_cfg_data;
                CFG_RULE_D:       r_rule[3]      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_idle <= '0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            if (close) begin
                r_fill <= '0;
                r_idle <= '0;
            end else if (store) begin
                r_fill <= fill_new;
                r_idle <= '0;
            end else if (tick) begin
                r_idle <= idle_inc;
            end
            r_busy <= n_busy;
            if (close && !bad) begin
                r_bank <= ~r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_excl <= excl_new;
            r_last <= i_rx_byte;
            r_type <= type_new;
        end
    end

endmodule

### hw/rtl/bpd_dq.sv
// bpd_dq: small descriptor queue between the collecting front and the replaying back.
// Depends on bpd_pkg; DEPTH must be a power of two.
module bpd_dq
    import bpd_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output t_desc o_desc,
    output logic  o_empty
);

    localparam int PW = $clog2(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

### hw/rtl/bpd_back.sv
// bpd_back: replays closed frames, one result per cycle while buffer has room.
// Depends on bpd_pkg; reads the frame RAM and feeds a two-entry result buffer.
module bpd_back
    import bpd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_dq_empty,
    input  t_desc                          i_desc,
    output logic                           o_dq_pop,
    output logic [$clog2(2*MAX_FRAME)-1:0] o_mem_addr,
    input  logic [BYTE_W-1:0]              i_mem_data,
    output t_release                       o_rel,
    output logic                           o_empty,
    input  logic                           i_pop,
    output t_result                        o_result
);

    localparam int AW = $clog2(2*MAX_FRAME);

    logic    r_active;
    t_desc   r_cur;
    t_len    r_pos;
    logic    r_rd_valid;
    t_result r_rd_meta;
    t_result r_ob [2];
    logic    r_ob_wr, r_ob_rd;
    logic [1:0] r_ob_cnt;

    logic       load, ob_pop, issue, is_last;
    logic [1:0] occ;
    t_result    meta, entry;

    assign ob_pop  = i_pop && (r_ob_cnt != '0);
    // buffer slots spoken for after this edge, reads in flight included
    assign occ     = r_ob_cnt + 2'(r_rd_valid) - 2'(ob_pop);
    assign issue   = r_active && (occ < 2'd2);
    assign is_last = r_cur.err || (r_pos + t_len'(1) == r_cur.len);
    assign load    = !r_active && !i_dq_empty;
    assign o_dq_pop = load;

    assign o_mem_addr = (r_cur.bank ? AW'(MAX_FRAME) : AW'(0)) + AW'(r_pos);

    assign meta.status = r_cur.err;
    assign meta.data   = '0;
    assign meta.pos    = r_cur.err ? '0 : POS_W'(r_pos);
    assign meta.len    = POS_W'(r_cur.len);
    assign meta.last   = is_last;

    assign o_rel.valid = issue && is_last && !r_cur.err;
    assign o_rel.bank  = r_cur.bank;

    always_comb begin
        entry = r_rd_meta;
        if (r_rd_meta.status == STAT_GOOD) begin
            entry.data = i_mem_data;
        end
    end

    assign o_empty  = (r_ob_cnt == '0);
    assign o_result = r_ob[r_ob_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_rd_valid <= 1'b0;
            r_ob_wr    <= 1'b0;
            r_ob_rd    <= 1'b0;
            r_ob_cnt   <= '0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
            end else if (issue && is_last) begin
                r_active <= 1'b0;
            end
            r_rd_valid <= issue;
            if (r_rd_valid) begin
                r_ob_wr <= ~r_ob_wr;
            end
            if (ob_pop) begin
                r_ob_rd <= ~r_ob_rd;
            end
            r_ob_cnt <= r_ob_cnt + 2'(r_rd_valid) - 2'(ob_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_desc;
            r_pos <= '0;
        end else if (issue) begin
            r_pos <= r_pos + t_len'(1);
        end
        r_rd_meta <= meta;
        if (r_rd_valid) begin
            r_ob[r_ob_wr] <= entry;
        end
    end

endmodule

### hw/rtl/bang_packet_deframer_checksum.sv
// Channel   | Handshake         | Payload
// ----------+-------------------+--------------------------------------------------
// input     | push / full       | i_opcode, i_rx_byte
// result    | pop / empty       | o_frame_status, o_frame_byte, o_byte_position,
//           |                   | o_frame_length, o_last_of_frame
// config    | i_cfg_we          | i_cfg_idx, i_cfg_data
//
// One byte or idle tick is taken per cycle while full is low; a frame closes at the edge of
// its closing item. With the back end idle, queue, load and RAM read lead to the first
// result; then one result per cycle while the buffer has room, bound by the RAM read port;
// results wait until popped; the back end idles between frames. Good frames alternate two
// RAM banks; full rises while the next bank is in replay or the descriptor queue is full.
// Synchronous active-low reset; no clearing pass, the RAM is only read where written.
// Top level: bang packet deframer with inverted-sum checksum.
// Depends on bpd_pkg, bpd_ram, bpd_front, bpd_dq, bpd_back.
module bang_packet_deframer_checksum
    import bpd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int DQ_DEPTH  = DQ_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_opcode,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_frame_status,
    output logic [BYTE_W-1:0]    o_frame_byte,
    output logic [POS_W-1:0]     o_byte_position,
    output logic [POS_W-1:0]     o_frame_length,
    output logic                 o_last_of_frame,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(2*MAX_FRAME);

    logic              dq_push, dq_full, dq_pop, dq_empty;
    t_desc             desc_in, desc_out;
    t_release          rel;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [BYTE_W-1:0] mem_wdata, mem_rdata;
    t_result           result;

    bpd_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_opcode   (i_opcode),
        .i_rx_byte  (i_rx_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_dq_full  (dq_full),
        .o_dq_push  (dq_push),
        .o_desc     (desc_in),
        .i_rel      (rel),
        .o_mem_we   (mem_we),
        .o_mem_addr (mem_waddr),
        .o_mem_data (mem_wdata)
    );

    bpd_dq #(.DEPTH(DQ_DEPTH)) u_dq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dq_push),
        .i_desc  (desc_in),
        .o_full  (dq_full),
        .i_pop   (dq_pop),
        .o_desc  (desc_out),
        .o_empty (dq_empty)
    );

    bpd_ram #(.WIDTH(BYTE_W), .DEPTH(2*MAX_FRAME)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bpd_back #(.MAX_FRAME(MAX_FRAME)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dq_empty (dq_empty),
        .i_desc     (desc_out),
        .o_dq_pop   (dq_pop),
        .o_mem_addr (mem_raddr),
        .i_mem_data (mem_rdata),
        .o_rel      (rel),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (result)
    );

    assign o_frame_status  = result.status;
    assign o_frame_byte    = result.data;
    assign o_byte_position = result.pos;
    assign o_frame_length  = result.len;
    assign o_last_of_frame = result.last;

endmodule

### hw/rtl/bpd_checker.sv
// bpd_checker: port-level assertions for the bang packet deframer, bound to the top level.
// Depends on bpd_pkg.
module bpd_checker
    import bpd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 empty,
    input logic                 pop,
    input logic                 o_frame_status,
    input logic [BYTE_W-1:0]    o_frame_byte,
    input logic [POS_W-1:0]     o_byte_position,
    input logic [POS_W-1:0]     o_frame_length,
    input logic                 o_last_of_frame
);

    // reset drops every pending result
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a checksum failure is one lone zeroed result
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_status == STAT_BAD) |->
            (o_frame_byte == '0 && o_byte_position == '0 && o_last_of_frame))
        else $error("malformed error result");

    // the last byte of a good frame sits at length minus one
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_status == STAT_GOOD && o_last_of_frame) |->
            (POS_W'(o_byte_position + POS_W'(1)) == o_frame_length))
        else $error("last marker at wrong position");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_frame_byte) &&
            $stable(o_byte_position) && $stable(o_frame_status)))
        else $error("waiting result changed before pop");

endmodule

bind bang_packet_deframer_checksum bpd_checker u_bpd_checker (.*);
